[rtl/rrbb_pkg.sv]
`default_nettype none
package rrbb_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int SIZE_W     = 9;   // region_width / region_height
  localparam int R_W        = 7;   // radius style registers
  localparam int CH_W       = 8;
  localparam int COLOR_W    = 3 * CH_W;
  localparam int PIX_W      = 4 * CH_W;
  localparam int CNT_W      = 8;   // window sample count, at most 2*127+1
  localparam int DIV_W      = 16;  // window sum, also holds any region side

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RADIUS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CORNER = 3'd5;

  localparam logic [SIZE_W-1:0] RST_WIDTH      = 9'd16;
  localparam logic [SIZE_W-1:0] RST_HEIGHT     = 9'd16;
  localparam logic [R_W-1:0]    RST_DIVISOR    = 7'd8;
  localparam logic [R_W-1:0]    RST_MIN_RADIUS = 7'd2;
  localparam logic [R_W-1:0]    RST_MAX_RADIUS = 7'd12;
  localparam logic [R_W-1:0]    RST_MAX_CORNER = 7'd12;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef struct packed {
    logic load_we;
    logic fetch_rd;
    logic early;
    logic setup_go;
    logic setup_latch;
    logic pass_init;
    logic pass_v_sel;
    logic line_init;
    logic line_next;
    logic step_rd;
    logic step_acc;
    logic div_go;
    logic mask_eval;
    logic wr;
  } rrbb_cmd_t;

  typedef struct packed {
    logic load_last;
    logic thin;
    logic fetch_last;
    logic div_done;
    logic step_out;
    logic line_end;
    logic pass_end;
    logic pass_v;
  } rrbb_sts_t;

endpackage
`default_nettype wire

[rtl/rounded_region_box_blur.sv]
`default_nettype none
// Load beats and fetch beats: one per cycle while the output is free; a fetch result shows in the cycle after its beat.
// Blur, after the last load beat (skipped if the region is under 2 wide or high): per pass,
// each line takes r lead-in steps (radius r), then a step and a bit-serial window-mean divide
// per pixel. Input is stalled while the blur runs.
// Synchronous active-low reset: back to loading, registers to their defaults, memories kept.
module rounded_region_box_blur import rrbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [PIX_W-1:0]      in_tdata,   // blue_in, green_in, red_in, alpha_in
  input  wire logic                  in_tuser,   // cmd: 0 load, 1 fetch
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [PIX_W-1:0]      out_tdata,  // blue_out, green_out, red_out, alpha_out
  output logic                       out_tuser,  // ready_res
  output logic                       out_tlast,  // last pixel of the region
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers; the user writes them only while idle, the block itself does not enforce it
  logic [SIZE_W-1:0] width_r, height_r;
  logic [R_W-1:0]    divisor_r, min_rad_r, max_rad_r, max_corner_r;
  logic              cfg_beat;

  rrbb_cmd_t cmd;
  rrbb_sts_t sts;

  assign cfg_ready = 1'b1;
  assign cfg_beat  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      divisor_r    <= RST_DIVISOR;
      min_rad_r    <= RST_MIN_RADIUS;
      max_rad_r    <= RST_MAX_RADIUS;
      max_corner_r <= RST_MAX_CORNER;
    end else if (cfg_beat) begin
      unique case (cfg_index)
        REG_WIDTH:      width_r      <= cfg_data;
        REG_HEIGHT:     height_r     <= cfg_data;
        REG_DIVISOR:    divisor_r    <= R_W'(cfg_data);
        REG_MIN_RADIUS: min_rad_r    <= R_W'(cfg_data);
        REG_MAX_RADIUS: max_rad_r    <= R_W'(cfg_data);
        REG_MAX_CORNER: max_corner_r <= R_W'(cfg_data);
        default: ;  // unmapped index, beat dropped
      endcase
    end
  end

  // sequencer: load, radius setup, horizontal pass, vertical pass, fetch
  rrbb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // pixel stores, sliding window sums, dividers and corner mask
  rrbb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .pix_in         (in_tdata),
    .pix_out        (out_tdata),
    .res_valid      (out_tuser),
    .res_last       (out_tlast),
    .cfg_width      (width_r),
    .cfg_height     (height_r),
    .cfg_divisor    (divisor_r),
    .cfg_min_radius (min_rad_r),
    .cfg_max_radius (max_rad_r),
    .cfg_max_corner (max_corner_r)
  );

endmodule
`default_nettype wire

[rtl/rrbb_div.sv]
`default_nettype none
module rrbb_div import rrbb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic      [DIV_W-1:0] quotient,
  output logic                  done
);

  localparam int STEP_W = $clog2(DIV_W);

  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt, dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [CNT_W:0]    trial;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[DIV_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? CNT_W'(trial - {1'b0, dsr_r}) : CNT_W'(trial);
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

[rtl/rrbb_dp.sv]
`default_nettype none
module rrbb_dp import rrbb_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rrbb_cmd_t         cmd,
  output rrbb_sts_t              sts,
  input  wire logic [PIX_W-1:0]  pix_in,
  output logic      [PIX_W-1:0]  pix_out,
  output logic                   res_valid,
  output logic                   res_last,
  input  wire logic [SIZE_W-1:0] cfg_width,
  input  wire logic [SIZE_W-1:0] cfg_height,
  input  wire logic [R_W-1:0]    cfg_divisor,
  input  wire logic [R_W-1:0]    cfg_min_radius,
  input  wire logic [R_W-1:0]    cfg_max_radius,
  input  wire logic [R_W-1:0]    cfg_max_corner
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int T_W     = ((DIM_W > R_W + 1) ? DIM_W : R_W + 1) + 1;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W  = $clog2(DEPTH);

  // memories
  logic [COLOR_W-1:0] cmem [DEPTH];
  logic [CH_W-1:0]    amem [DEPTH];
  logic [COLOR_W-1:0] hmem [DEPTH];
  logic [COLOR_W-1:0] ca_r, cb_r, ha_r, hb_r;
  logic [CH_W-1:0]    al_r;

  // region size
  logic [DIM_W-1:0] lat_w_r, lat_h_r, w_cfg, h_cfg, w_eff, h_eff;
  logic [DIM_W-1:0] lcol_r, lrow_r, fcol_r, frow_r;
  logic [ADDR_W-1:0] load_ptr_r, fetch_ptr_r;
  logic             first_load;

  // blur parameters
  logic [R_W-1:0]   rad_r, cr_r, rad_c, cr_c;
  logic [CNT_W-1:0] r2p1_r;
  logic [13:0]      cr2_r;
  logic [DIM_W-1:0] side, side4, cr1;
  logic [DIV_W-1:0] raw1;
  logic [R_W-1:0]   div_eff;

  // pass / line walk
  logic              pass_v_r;
  logic [DIM_W-1:0]  line_r, outc_r, n_len, n_lines;
  logic [ADDR_W-1:0] base_r, add_ptr_r, rem_ptr_r, out_ptr_r, stride;
  logic [T_W-1:0]    t_r;
  logic              add_en, rem_en, line_last, line_end_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [COLOR_W-1:0] src_a, src_b;
  logic [DIV_W-1:0]  quo [3];
  logic [2:0]        dv_done;
  logic [COLOR_W-1:0] mean;

  // corner mask
  logic [T_W-1:0]   xv, yv, wv, hv, crv, dxv, dyv;
  logic             xin, yin, flag_r, mask_in;
  logic [CH_W-1:0]  dx8, dy8;
  logic [15:0]      dx2_r, dy2_r;

  // result flags
  logic             outz_r, outlast_r;

  always_comb begin
    w_cfg = (cfg_width == '0) ? DIM_W'(1) :
            (32'(cfg_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_width);
    h_cfg = (cfg_height == '0) ? DIM_W'(1) :
            (32'(cfg_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : DIM_W'(cfg_height);
    first_load = (load_ptr_r == '0);
    w_eff = first_load ? w_cfg : lat_w_r;
    h_eff = first_load ? h_cfg : lat_h_r;
  end

  // radius and corner radius
  always_comb begin
    side    = (lat_w_r < lat_h_r) ? lat_w_r : lat_h_r;
    side4   = side >> 2;
    cr1     = (side4 == '0) ? DIM_W'(1) : side4;
    cr_c    = (T_W'(cr1) > T_W'(cfg_max_corner)) ? cfg_max_corner : R_W'(cr1);
    div_eff = (cfg_divisor == '0) ? R_W'(1) : cfg_divisor;
    raw1    = (quo[0] < DIV_W'(cfg_min_radius)) ? DIV_W'(cfg_min_radius) : quo[0];
    rad_c   = (raw1 > DIV_W'(cfg_max_radius)) ? cfg_max_radius : R_W'(raw1);
  end

  always_comb begin
    n_len     = pass_v_r ? lat_h_r : lat_w_r;
    n_lines   = pass_v_r ? lat_w_r : lat_h_r;
    stride    = pass_v_r ? ADDR_W'(lat_w_r) : ADDR_W'(1);
    add_en    = t_r < T_W'(n_len);
    rem_en    = t_r >= T_W'(r2p1_r);
    line_last = t_r == (T_W'(n_len) - T_W'(1) + T_W'(rad_r));
    src_a     = pass_v_r ? ha_r : ca_r;
    src_b     = pass_v_r ? hb_r : cb_r;
    mean      = {quo[2][CH_W-1:0], quo[1][CH_W-1:0], quo[0][CH_W-1:0]};
  end

  // corner test: column is the line, row is the output index
  always_comb begin
    xv  = T_W'(line_r);
    yv  = T_W'(outc_r);
    wv  = T_W'(lat_w_r);
    hv  = T_W'(lat_h_r);
    crv = T_W'(cr_r);
    xin = (xv >= crv) && (xv < wv - crv);
    yin = (yv >= crv) && (yv < hv - crv);
    dxv = (xv < crv) ? crv - xv : xv - (wv - crv - T_W'(1));
    dyv = (yv < crv) ? crv - yv : yv - (hv - crv - T_W'(1));
    dx8 = CH_W'(dxv);
    dy8 = CH_W'(dyv);
    mask_in = flag_r || ((17'(dx2_r) + 17'(dy2_r)) <= 17'(cr2_r));
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      cmem[load_ptr_r] <= pix_in[COLOR_W-1:0];
    end else if (cmd.wr && pass_v_r && mask_in) begin
      cmem[out_ptr_r] <= mean;
    end
    if (cmd.load_we) begin
      amem[load_ptr_r] <= pix_in[PIX_W-1:COLOR_W];
    end
    if (cmd.wr && !pass_v_r) begin
      hmem[out_ptr_r] <= mean;
    end
    if (cmd.fetch_rd || cmd.step_rd) begin
      ca_r <= cmem[cmd.fetch_rd ? fetch_ptr_r : add_ptr_r];
    end
    if (cmd.step_rd) begin
      cb_r <= cmem[rem_ptr_r];
      ha_r <= hmem[add_ptr_r];
      hb_r <= hmem[rem_ptr_r];
    end
    if (cmd.fetch_rd) begin
      al_r <= amem[fetch_ptr_r];
    end
  end

  // load and fetch walks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      lcol_r      <= '0;
      lrow_r      <= '0;
      fetch_ptr_r <= '0;
      fcol_r      <= '0;
      frow_r      <= '0;
      lat_w_r     <= '0;
      lat_h_r     <= '0;
      outz_r      <= 1'b1;
      outlast_r   <= 1'b0;
    end else begin
      if (cmd.load_we) begin
        if (first_load) begin
          lat_w_r <= w_cfg;
          lat_h_r <= h_cfg;
        end
        if (sts.load_last) begin
          load_ptr_r <= '0;
          lcol_r     <= '0;
          lrow_r     <= '0;
        end else begin
          load_ptr_r <= load_ptr_r + 1'b1;
          if (lcol_r == w_eff - 1'b1) begin
            lcol_r <= '0;
            lrow_r <= lrow_r + 1'b1;
          end else begin
            lcol_r <= lcol_r + 1'b1;
          end
        end
      end
      if (cmd.fetch_rd) begin
        if (sts.fetch_last) begin
          fetch_ptr_r <= '0;
          fcol_r      <= '0;
          frow_r      <= '0;
        end else begin
          fetch_ptr_r <= fetch_ptr_r + 1'b1;
          if (fcol_r == lat_w_r - 1'b1) begin
            fcol_r <= '0;
            frow_r <= frow_r + 1'b1;
          end else begin
            fcol_r <= fcol_r + 1'b1;
          end
        end
      end
      if (cmd.fetch_rd || cmd.early) begin
        outz_r    <= cmd.early;
        outlast_r <= cmd.fetch_rd && sts.fetch_last;
      end
    end
  end

  // blur walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_v_r   <= 1'b0;
      line_r     <= '0;
      base_r     <= '0;
      t_r        <= '0;
      line_end_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cmd.pass_init) begin
        pass_v_r <= cmd.pass_v_sel;
        line_r   <= '0;
        base_r   <= '0;
      end else if (cmd.line_next) begin
        line_r <= line_r + 1'b1;
        base_r <= base_r + (pass_v_r ? ADDR_W'(1) : ADDR_W'(lat_w_r));
      end
      if (cmd.line_init) begin
        t_r        <= '0;
        cnt_r      <= '0;
        line_end_r <= 1'b0;
      end else if (cmd.step_acc) begin
        t_r        <= t_r + 1'b1;
        cnt_r      <= cnt_r + CNT_W'(add_en) - CNT_W'(rem_en);
        line_end_r <= line_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.line_init) begin
      add_ptr_r <= base_r;
      rem_ptr_r <= base_r;
      out_ptr_r <= base_r;
      outc_r    <= '0;
    end else begin
      if (cmd.step_acc && add_en) add_ptr_r <= add_ptr_r + stride;
      if (cmd.step_acc && rem_en) rem_ptr_r <= rem_ptr_r + stride;
      if (cmd.wr) begin
        out_ptr_r <= out_ptr_r + stride;
        outc_r    <= outc_r + 1'b1;
      end
    end
    if (cmd.setup_latch) begin
      rad_r  <= rad_c;
      r2p1_r <= {rad_c, 1'b1};
      cr_r   <= cr_c;
      cr2_r  <= cr_c * cr_c;
    end
    if (cmd.mask_eval) begin
      flag_r <= (cr_r == '0) || xin || yin;
      dx2_r  <= dx8 * dx8;
      dy2_r  <= dy8 * dy8;
    end
  end

  // one window sum and one divider per color channel
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [DIV_W-1:0] sum_r;
    logic [DIV_W-1:0] dvd;
    logic [CNT_W-1:0] dsr;

    always_ff @(posedge clk) begin
      if (cmd.line_init) begin
        sum_r <= '0;
      end else if (cmd.step_acc) begin
        sum_r <= sum_r
               + (add_en ? DIV_W'(src_a[c*CH_W +: CH_W]) : '0)
               - (rem_en ? DIV_W'(src_b[c*CH_W +: CH_W]) : '0);
      end
    end

    if (c == 0) begin : g_shared
      assign dvd = cmd.setup_go ? DIV_W'(side) : sum_r;
      assign dsr = cmd.setup_go ? CNT_W'(div_eff) : cnt_r;
    end else begin : g_plain
      assign dvd = sum_r;
      assign dsr = cnt_r;
    end

    rrbb_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (cmd.div_go || cmd.setup_go),
      .dividend (dvd),
      .divisor  (dsr),
      .quotient (quo[c]),
      .done     (dv_done[c])
    );
  end

  always_comb begin
    sts.load_last  = (lcol_r == w_eff - 1'b1) && (lrow_r == h_eff - 1'b1);
    sts.thin       = (w_eff < DIM_W'(2)) || (h_eff < DIM_W'(2));
    sts.fetch_last = (fcol_r == lat_w_r - 1'b1) && (frow_r == lat_h_r - 1'b1);
    sts.div_done   = dv_done[0];
    sts.step_out   = t_r >= T_W'(rad_r);
    sts.line_end   = line_end_r;
    sts.pass_end   = line_r == n_lines - 1'b1;
    sts.pass_v     = pass_v_r;
  end

  assign pix_out   = outz_r ? '0 : {al_r, ca_r};
  assign res_valid = !outz_r;
  assign res_last  = outlast_r;

  logic unused_dv;
  assign unused_dv = dv_done[1] ^ dv_done[2];

endmodule
`default_nettype wire

[rtl/rrbb_ctrl.sv]
`default_nettype none
module rrbb_ctrl import rrbb_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  input  wire logic      in_kind,
  output logic           in_tready,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output rrbb_cmd_t      cmd,
  input  wire rrbb_sts_t sts
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_RAD   = 4'd1;
  localparam logic [3:0] S_RADW  = 4'd2;
  localparam logic [3:0] S_LINE  = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DVG   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_WR    = 4'd8;
  localparam logic [3:0] S_FETCH = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, beat, ld_beat, ft_beat;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    in_tready = ((state_r == S_LOAD) || (state_r == S_FETCH)) && out_free;
    beat      = in_tvalid && in_tready;
    ld_beat   = beat && (in_kind == CMD_LOAD);
    ft_beat   = beat && (in_kind == CMD_FETCH);
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.load_we = ld_beat;
        cmd.early   = ft_beat;
        if (ld_beat && sts.load_last) begin
          state_nxt = sts.thin ? S_FETCH : S_RAD;
        end
      end
      S_RAD: begin
        cmd.setup_go = 1'b1;
        state_nxt    = S_RADW;
      end
      S_RADW: begin
        if (sts.div_done) begin
          cmd.setup_latch = 1'b1;
          cmd.pass_init   = 1'b1;
          state_nxt       = S_LINE;
        end
      end
      S_LINE: begin
        cmd.line_init = 1'b1;
        state_nxt     = S_RD;
      end
      S_RD: begin
        cmd.step_rd = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.step_acc = 1'b1;
        state_nxt    = sts.step_out ? S_DVG : S_RD;
      end
      S_DVG: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.mask_eval = 1'b1;
        if (sts.div_done) state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (!sts.line_end) begin
          state_nxt = S_RD;
        end else if (!sts.pass_end) begin
          cmd.line_next = 1'b1;
          state_nxt     = S_LINE;
        end else if (sts.pass_v) begin
          state_nxt = S_FETCH;
        end else begin
          cmd.pass_init  = 1'b1;
          cmd.pass_v_sel = 1'b1;
          state_nxt      = S_LINE;
        end
      end
      S_FETCH: begin
        cmd.fetch_rd = ft_beat;
        if (ft_beat && sts.fetch_last) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    if (ft_beat) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_no_input_while_blurring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD && state_r != S_FETCH) |-> !in_tready)
    else $error("input taken during blur");

  a_no_overwrite_of_result: assert property (@(posedge clk) disable iff (!rst_n)
    ft_beat |-> (!out_valid_r || out_tready))
    else $error("fetch accepted while result stalled");

  a_fetch_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    ft_beat |=> out_valid_r)
    else $error("fetch produced no result");

  a_single_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_we && cmd.wr))
    else $error("load and blur write collide");

endmodule
`default_nettype wire
